// ===== hdl/cptoi_pkg.sv =====
`default_nettype none

package cptoi_pkg;

   // fixed-point format
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int POS_W  = 32;
   localparam int RAD_W  = 31;
   localparam int TIME_W = 31;

   // datapath widths
   localparam int DIF_W    = POS_W + 1;        // relative position and velocity
   localparam int RSUM_W   = RAD_W + 1;        // radius sum
   localparam int PROD_W   = 2 * DIF_W;        // one square or cross product
   localparam int MAG_W    = PROD_W;           // a, |h|, |c|
   localparam int H_W      = MAG_W + 1;        // signed h and c
   localparam int LIMB_W   = MAG_W / 2;        // half of a wide operand
   localparam int LIMB_P_W = 2 * LIMB_W;       // partial product
   localparam int SQ_W     = 2 * MAG_W;        // h*h and a*|c|
   localparam int REM_W    = SQ_W + 2;         // discriminant magnitude
   localparam int E_W      = REM_W + 1;        // signed discriminant
   localparam int ROOT_W   = REM_W / 2;        // floor square root
   localparam int N_W      = ROOT_W + 2;       // signed -h +/- s
   localparam int NUM_W    = N_W - 1 + FRAC_BITS;
   localparam int Q_W      = 32;               // quotient, saturates at 2^31
   localparam int DIV_W    = MAG_W + Q_W;      // divider partial remainder

   localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(1 << FRAC_BITS);

   // data that rides along the square root pipeline
   typedef struct packed {
      logic [MAG_W-1:0]      a;
      logic signed [H_W-1:0] h;
      logic                  ok;
   } side_type;

   // control that rides along the divider
   typedef struct packed {
      logic [1:0] neg;
      logic       ok;
   } div_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/cptoi_req_if.sv =====
`default_nettype none

interface cptoi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cptoi_pkg::POS_W-1:0]    first_pos_x;
   logic signed [cptoi_pkg::POS_W-1:0]    first_pos_y;
   logic signed [cptoi_pkg::POS_W-1:0]    first_vel_x;
   logic signed [cptoi_pkg::POS_W-1:0]    first_vel_y;
   logic [cptoi_pkg::RAD_W-1:0]           first_radius;
   logic signed [cptoi_pkg::POS_W-1:0]    second_pos_x;
   logic signed [cptoi_pkg::POS_W-1:0]    second_pos_y;
   logic signed [cptoi_pkg::POS_W-1:0]    second_vel_x;
   logic signed [cptoi_pkg::POS_W-1:0]    second_vel_y;
   logic [cptoi_pkg::RAD_W-1:0]           second_radius;

   modport source (
      output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
      output second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius,
      input  ready
   );

   modport sink (
      input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
      input  second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/cptoi_rsp_if.sv =====
`default_nettype none

interface cptoi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [cptoi_pkg::TIME_W-1:0]   contact_time;

   modport source (output valid, hit, contact_time, input ready);
   modport sink (input valid, hit, contact_time, output ready);
endinterface

`default_nettype wire

// ===== hdl/circle_pair_time_of_impact_core.sv =====
// Throughput: one pair per cycle while the output skid register is empty; the 67-stage
// square root and 32-stage divider set depth.
// A full output skid register stalls every stage at once; nothing is dropped or repeated.
// Reset clears all valid bits, the skid valid bit among them, and loads period_ff with 1.0.
`default_nettype none

module circle_pair_time_of_impact_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [cptoi_pkg::TIME_W-1:0]    csr_write_data,
   cptoi_req_if.sink                       req_chan,
   cptoi_rsp_if.source                     rsp_chan
);

   localparam int Dw  = cptoi_pkg::DIF_W;
   localparam int Sw  = cptoi_pkg::RSUM_W;
   localparam int Pw  = cptoi_pkg::PROD_W;
   localparam int Mw  = cptoi_pkg::MAG_W;
   localparam int Hw  = cptoi_pkg::H_W;
   localparam int Lw  = cptoi_pkg::LIMB_W;
   localparam int Lpw = cptoi_pkg::LIMB_P_W;
   localparam int Qsw = cptoi_pkg::SQ_W;
   localparam int Rw  = cptoi_pkg::REM_W;
   localparam int Ew  = cptoi_pkg::E_W;
   localparam int Nw  = cptoi_pkg::N_W;
   localparam int Numw = cptoi_pkg::NUM_W;
   localparam int Qw  = cptoi_pkg::Q_W;
   localparam int Tw  = cptoi_pkg::TIME_W;

   logic adv;

   logic [Tw-1:0] period_ff;

   // stage 1: relative motion
   logic v1_ff;
   logic signed [Dw-1:0] dx_ff, dy_ff, dvx_ff, dvy_ff;
   logic [Sw-1:0] tr_ff;

   // stage 2: products
   logic v2_ff;
   logic signed [Pw-1:0] p_vxx_ff, p_vyy_ff, p_vxdx_ff, p_vydy_ff, p_dxx_ff, p_dyy_ff;
   logic [2*Sw-1:0] p_trr_ff;

   // stage 3: quadratic terms
   logic v3_ff;
   logic [Mw-1:0] a3_ff;
   logic signed [Hw-1:0] h3_ff, c3_ff;

   // stage 4: partial products of h*h and a*|c|
   logic v4_ff;
   logic [Mw-1:0] hmag_in, cmag_in;
   logic [Lpw-1:0] hll_ff, hlh_ff, hhh_ff, all_ff, alh_ff, ahl_ff, ahh_ff;
   logic [Mw-1:0] a4_ff;
   logic signed [Hw-1:0] h4_ff;
   logic c_neg4_ff, a_nz4_ff;

   // stage 5: full products
   logic v5_ff;
   logic [Qsw-1:0] hsq_ff, acm_ff;
   logic [Mw-1:0] a5_ff;
   logic signed [Hw-1:0] h5_ff;
   logic c_neg5_ff, a_nz5_ff;

   // stage 6: discriminant
   logic v6_ff;
   logic signed [Ew-1:0] e_in;
   logic ok_in;
   logic [Rw-1:0] sq_rem_ff;
   cptoi_pkg::side_type sq_side_ff;

   // square root unit
   logic sq_valid;
   logic [cptoi_pkg::ROOT_W-1:0] sq_root;
   cptoi_pkg::side_type sq_side;

   // stage 7: numerators
   logic v7_ff;
   logic signed [Nw-1:0] n_ff [2];
   logic [Mw-1:0] a7_ff;
   logic ok7_ff;

   // stage 8: divider operands
   logic dv_v_ff;
   logic [Nw-1:0] nmag_in [2];
   logic [Numw-1:0] dv_num_ff [2];
   logic [Mw-1:0] dv_den_ff;
   cptoi_pkg::div_ctl_type dv_ctl_ff;

   // divider unit
   logic dq_valid;
   logic [Qw-1:0] dq [2];
   cptoi_pkg::div_ctl_type dq_ctl;

   // stage 9: root selection
   logic pos1, pos2, in1, in2;
   logic hit_in;
   logic [Qw-1:0] res_in;
   logic p_v_ff, p_hit_ff;
   logic [Tw-1:0] p_time_ff;

   // output skid
   logic skid_v_ff, skid_hit_ff;
   logic [Tw-1:0] skid_time_ff;
   logic skid_v_in;

   assign adv = !skid_v_ff;
   assign req_chan.ready = adv;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= cptoi_pkg::PERIOD_RESET;
      end else if (csr_write_en) begin
         period_ff <= csr_write_data;
      end
   end

   // magnitudes and limb split for the wide products
   always_comb begin
      hmag_in = h3_ff[Hw-1] ? Mw'(-h3_ff) : Mw'(h3_ff);
      cmag_in = c3_ff[Hw-1] ? Mw'(-c3_ff) : Mw'(c3_ff);
   end

   // discriminant and the gate for a real, moving solution
   always_comb begin
      if (c_neg5_ff) begin
         e_in = Ew'(hsq_ff) + Ew'(acm_ff);
      end else begin
         e_in = Ew'(hsq_ff) - Ew'(acm_ff);
      end
      ok_in = a_nz5_ff && !e_in[Ew-1];
   end

   // numerator magnitudes
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         nmag_in[l] = n_ff[l][Nw-1] ? Nw'(-n_ff[l]) : Nw'(n_ff[l]);
      end
   end

   // front pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         dv_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= sq_valid;
         dv_v_ff <= v7_ff;
      end
      if (adv) begin
         dx_ff  <= Dw'(req_chan.first_pos_x) - Dw'(req_chan.second_pos_x);
         dy_ff  <= Dw'(req_chan.first_pos_y) - Dw'(req_chan.second_pos_y);
         dvx_ff <= Dw'(req_chan.first_vel_x) - Dw'(req_chan.second_vel_x);
         dvy_ff <= Dw'(req_chan.first_vel_y) - Dw'(req_chan.second_vel_y);
         tr_ff  <= Sw'(req_chan.first_radius) + Sw'(req_chan.second_radius);

         p_vxx_ff  <= Pw'(dvx_ff) * Pw'(dvx_ff);
         p_vyy_ff  <= Pw'(dvy_ff) * Pw'(dvy_ff);
         p_vxdx_ff <= Pw'(dvx_ff) * Pw'(dx_ff);
         p_vydy_ff <= Pw'(dvy_ff) * Pw'(dy_ff);
         p_dxx_ff  <= Pw'(dx_ff) * Pw'(dx_ff);
         p_dyy_ff  <= Pw'(dy_ff) * Pw'(dy_ff);
         p_trr_ff  <= (2*Sw)'(tr_ff) * (2*Sw)'(tr_ff);

         a3_ff <= Mw'($unsigned(p_vxx_ff)) + Mw'($unsigned(p_vyy_ff));
         h3_ff <= Hw'(p_vxdx_ff) + Hw'(p_vydy_ff);
         c3_ff <= Hw'(p_dxx_ff) + Hw'(p_dyy_ff) - $signed(Hw'(p_trr_ff));

         hll_ff <= Lpw'(hmag_in[Lw-1:0]) * Lpw'(hmag_in[Lw-1:0]);
         hlh_ff <= Lpw'(hmag_in[Lw-1:0]) * Lpw'(hmag_in[Mw-1:Lw]);
         hhh_ff <= Lpw'(hmag_in[Mw-1:Lw]) * Lpw'(hmag_in[Mw-1:Lw]);
         all_ff <= Lpw'(a3_ff[Lw-1:0]) * Lpw'(cmag_in[Lw-1:0]);
         alh_ff <= Lpw'(a3_ff[Lw-1:0]) * Lpw'(cmag_in[Mw-1:Lw]);
         ahl_ff <= Lpw'(a3_ff[Mw-1:Lw]) * Lpw'(cmag_in[Lw-1:0]);
         ahh_ff <= Lpw'(a3_ff[Mw-1:Lw]) * Lpw'(cmag_in[Mw-1:Lw]);
         a4_ff <= a3_ff;
         h4_ff <= h3_ff;
         c_neg4_ff <= c3_ff[Hw-1];
         a_nz4_ff <= (a3_ff != '0);

         hsq_ff <= Qsw'(hll_ff) + (Qsw'(hlh_ff) << (Lw + 1)) + (Qsw'(hhh_ff) << (2 * Lw));
         acm_ff <= Qsw'(all_ff) + ((Qsw'(alh_ff) + Qsw'(ahl_ff)) << Lw)
                   + (Qsw'(ahh_ff) << (2 * Lw));
         a5_ff <= a4_ff;
         h5_ff <= h4_ff;
         c_neg5_ff <= c_neg4_ff;
         a_nz5_ff <= a_nz4_ff;

         sq_rem_ff     <= ok_in ? Rw'(e_in) : '0;
         sq_side_ff.a  <= a5_ff;
         sq_side_ff.h  <= h5_ff;
         sq_side_ff.ok <= ok_in;

         n_ff[0] <= Nw'(sq_root) - Nw'(sq_side.h);
         n_ff[1] <= Nw'(0) - Nw'(sq_root) - Nw'(sq_side.h);
         a7_ff   <= sq_side.a;
         ok7_ff  <= sq_side.ok;

         for (int l = 0; l < 2; l++) begin
            dv_num_ff[l] <= Numw'(nmag_in[l][Nw-2:0]) << cptoi_pkg::FRAC_BITS;
         end
         dv_den_ff        <= a7_ff;
         dv_ctl_ff.neg[0] <= n_ff[0][Nw-1];
         dv_ctl_ff.neg[1] <= n_ff[1][Nw-1];
         dv_ctl_ff.ok     <= ok7_ff;
      end
   end

   cptoi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v6_ff),
      .in_rem    (sq_rem_ff),
      .in_side   (sq_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   cptoi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dv_v_ff),
      .in_num    (dv_num_ff),
      .in_den    (dv_den_ff),
      .in_ctl    (dv_ctl_ff),
      .out_valid (dq_valid),
      .out_q     (dq),
      .out_ctl   (dq_ctl)
   );

   // pick the earliest root inside the period
   always_comb begin
      pos1 = !dq_ctl.neg[0] && (dq[0] != '0);
      pos2 = !dq_ctl.neg[1] && (dq[1] != '0);
      in1  = pos1 && (dq[0] <= Qw'(period_ff));
      in2  = pos2 && (dq[1] <= Qw'(period_ff));
      priority if (!dq_ctl.ok) begin
         hit_in = 1'b0;
         res_in = '0;
      end else if (in1) begin
         hit_in = 1'b1;
         res_in = (pos2 && (dq[1] < dq[0])) ? dq[1] : dq[0];
      end else if (in2) begin
         hit_in = 1'b1;
         res_in = dq[1];
      end else begin
         hit_in = 1'b0;
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= dq_valid;
      end
      if (adv) begin
         p_hit_ff  <= hit_in;
         p_time_ff <= res_in[Tw-1:0];
      end
   end

   // output skid: holds a beat the sink did not take
   assign skid_v_in = (skid_v_ff || p_v_ff) && !rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
      if (!skid_v_ff) begin
         skid_hit_ff  <= p_hit_ff;
         skid_time_ff <= p_time_ff;
      end
   end

   assign rsp_chan.valid        = skid_v_ff || p_v_ff;
   assign rsp_chan.hit          = skid_v_ff ? skid_hit_ff : p_hit_ff;
   assign rsp_chan.contact_time = skid_v_ff ? skid_time_ff : p_time_ff;

   // checks
   a_miss_zero_time: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.hit |-> rsp_chan.contact_time == '0)
      else $error("miss beat carries a nonzero contact time");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.hit |-> rsp_chan.contact_time != '0)
      else $error("hit beat carries a zero contact time");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_chan.ready |=> skid_v_ff && $stable(skid_time_ff)
         && $stable(skid_hit_ff))
      else $error("skid register lost a waiting beat");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(p_v_ff) && $stable(v1_ff) && $stable(p_time_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== hdl/cptoi_sqrt.sv =====
`default_nettype none

module cptoi_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [cptoi_pkg::REM_W-1:0]       in_rem,
   input  cptoi_pkg::side_type               in_side,
   output logic                              out_valid,
   output logic [cptoi_pkg::ROOT_W-1:0]      out_root,
   output cptoi_pkg::side_type               out_side
);

   localparam int Steps = cptoi_pkg::ROOT_W;
   localparam int Rw    = cptoi_pkg::REM_W;

   logic [Rw-1:0]    rem_ff   [Steps];
   logic [Rw-1:0]    rem_in   [Steps];
   logic [Rw-1:0]    rem_src  [Steps];
   logic [Rw-1:0]    trial    [Steps];
   logic [Steps-1:0] root_ff  [Steps];
   logic [Steps-1:0] root_in  [Steps];
   logic [Steps-1:0] root_src [Steps];
   cptoi_pkg::side_type side_ff [Steps];
   logic [Steps-1:0] valid_ff;

   // one root bit per stage, most significant first
   always_comb begin
      rem_src[0]  = in_rem;
      root_src[0] = '0;
      for (int k = 1; k < Steps; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
      end
      for (int k = 0; k < Steps; k++) begin
         trial[k] = (Rw'(root_src[k]) << (Steps - k)) | (Rw'(1) << (2 * (Steps - 1 - k)));
         if (rem_src[k] >= trial[k]) begin
            rem_in[k]  = rem_src[k] - trial[k];
            root_in[k] = root_src[k] | (Steps'(1) << (Steps - 1 - k));
         end else begin
            rem_in[k]  = rem_src[k];
            root_in[k] = root_src[k];
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[Steps-2:0], in_valid};
      end
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < Steps; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < Steps; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_root  = root_ff[Steps-1];
   assign out_side  = side_ff[Steps-1];

endmodule

`default_nettype wire

// ===== hdl/cptoi_div.sv =====
`default_nettype none

module cptoi_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [cptoi_pkg::NUM_W-1:0]       in_num [2],
   input  logic [cptoi_pkg::MAG_W-1:0]       in_den,
   input  cptoi_pkg::div_ctl_type            in_ctl,
   output logic                              out_valid,
   output logic [cptoi_pkg::Q_W-1:0]         out_q [2],
   output cptoi_pkg::div_ctl_type            out_ctl
);

   localparam int Steps = cptoi_pkg::Q_W;
   localparam int Dw    = cptoi_pkg::DIV_W;
   localparam int Mw    = cptoi_pkg::MAG_W;

   logic [Dw-1:0]    rem_ff  [Steps][2];
   logic [Dw-1:0]    rem_in  [Steps][2];
   logic [Dw-1:0]    rem_src [Steps][2];
   logic [Steps-1:0] q_ff    [Steps][2];
   logic [Steps-1:0] q_in    [Steps][2];
   logic [Steps-1:0] q_src   [Steps][2];
   logic [Mw-1:0]    den_ff  [Steps];
   logic [Mw-1:0]    den_src [Steps];
   logic [Dw-1:0]    trial   [Steps];
   cptoi_pkg::div_ctl_type ctl_ff [Steps];
   logic [Steps-1:0] valid_ff;

   // first stage catches a quotient of 2^31 or more and saturates;
   // the rest is restoring division, one quotient bit per stage
   always_comb begin
      den_src[0] = in_den;
      for (int l = 0; l < 2; l++) begin
         rem_src[0][l] = Dw'(in_num[l]);
         q_src[0][l]   = '0;
      end
      for (int k = 1; k < Steps; k++) begin
         den_src[k] = den_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            rem_src[k][l] = rem_ff[k-1][l];
            q_src[k][l]   = q_ff[k-1][l];
         end
      end
      for (int k = 0; k < Steps; k++) begin
         trial[k] = Dw'(den_src[k]) << (Steps - 1 - k);
         for (int l = 0; l < 2; l++) begin
            if (rem_src[k][l] >= trial[k]) begin
               rem_in[k][l] = (k == 0) ? '0 : rem_src[k][l] - trial[k];
               q_in[k][l]   = q_src[k][l] | (Steps'(1) << (Steps - 1 - k));
            end else begin
               rem_in[k][l] = rem_src[k][l];
               q_in[k][l]   = q_src[k][l];
            end
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[Steps-2:0], in_valid};
      end
      if (en) begin
         ctl_ff[0] <= in_ctl;
         for (int k = 1; k < Steps; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         for (int k = 0; k < Steps; k++) begin
            den_ff[k] <= den_src[k];
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               q_ff[k][l]   <= q_in[k][l];
            end
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_q[0]  = q_ff[Steps-1][0];
   assign out_q[1]  = q_ff[Steps-1][1];
   assign out_ctl   = ctl_ff[Steps-1];

endmodule

`default_nettype wire
